@@ rtl/unit_fraction_sum_reducer_macros.svh @@
// assertion helpers included by the controller
`ifndef UNIT_FRACTION_SUM_REDUCER_MACROS_SVH
`define UNIT_FRACTION_SUM_REDUCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define UFSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, checked outside reset
`define UFSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/ufsr_pkg.sv @@
`timescale 1ns / 1ps

package ufsr_pkg;

    // datapath widths
    localparam int SUM_W   = 32;
    localparam int DENOM_W = 16;
    localparam int OUT_W   = 32;
    localparam int AW      = SUM_W + 1;
    localparam int PROD_W  = SUM_W + DENOM_W;
    localparam int CNT_W   = $clog2(SUM_W);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_N,
        S_MUL_D,
        S_ADD,
        S_GCD,
        S_DIV_T,
        S_DIV_B,
        S_FIN
    } t_state;

    // shared unit operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic [AW-1:0]        a;
        logic [AW-1:0]        b;
        logic [DENOM_W-1:0]   m;
    } t_alu_req;

    typedef struct packed {
        logic [PROD_W-1:0]    prod;
        logic [AW:0]          diff;
        logic                 zero;
    } t_alu_rsp;

    // one result item
    typedef struct packed {
        logic [OUT_W-1:0]     sum_numerator;
        logic [OUT_W-1:0]     sum_denominator;
        logic                 group_done;
        logic                 overflow;
        logic                 zero_denominator;
    } t_result;

endpackage

@@ rtl/ufsr_in_if.sv @@
`timescale 1ns / 1ps

interface ufsr_in_if;
    import ufsr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DENOM_W-1:0]   denominator;
    logic                 last_term;

    modport source (output valid, output denominator, output last_term, input ready);
    modport sink   (input valid, input denominator, input last_term, output ready);
endinterface

@@ rtl/ufsr_out_if.sv @@
`timescale 1ns / 1ps

interface ufsr_out_if;
    import ufsr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_W-1:0]     sum_numerator;
    logic [OUT_W-1:0]     sum_denominator;
    logic                 group_done;
    logic                 overflow;
    logic                 zero_denominator;

    modport source (output valid, output sum_numerator, output sum_denominator,
                    output group_done, output overflow, output zero_denominator,
                    input ready);
    modport sink   (input valid, input sum_numerator, input sum_denominator,
                    input group_done, input overflow, input zero_denominator,
                    output ready);
endinterface

@@ rtl/ufsr_alu.sv @@
`timescale 1ns / 1ps

module ufsr_alu (
    input  ufsr_pkg::t_alu_req i_req,
    output ufsr_pkg::t_alu_rsp o_rsp
);
    import ufsr_pkg::*;

    logic [AW:0] diff;

    // add or subtract with carry / borrow in the top bit
    always_comb begin
        if (i_req.op == ALU_ADD) begin
            diff = {1'b0, i_req.a} + {1'b0, i_req.b};
        end else begin
            diff = {1'b0, i_req.a} - {1'b0, i_req.b};
        end
    end

    // sum-width by denominator-width product
    assign o_rsp.prod = PROD_W'(i_req.a[SUM_W-1:0]) * PROD_W'(i_req.m);
    assign o_rsp.diff = diff;
    assign o_rsp.zero = (diff[AW-1:0] == '0);

endmodule

@@ rtl/ufsr_ctrl.sv @@
`timescale 1ns / 1ps
`include "unit_fraction_sum_reducer_macros.svh"

module ufsr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ufsr_pkg::DENOM_W-1:0]  i_denom,
    input  logic                          i_last,
    input  logic                          i_res_free,
    output logic                          o_ready,
    output logic                          o_res_valid,
    output ufsr_pkg::t_result             o_res
);
    import ufsr_pkg::*;

    t_state               r_state, n_state;
    logic [SUM_W-1:0]     r_num, n_num;
    logic [SUM_W-1:0]     r_den, n_den;
    logic                 r_ovf_seen, n_ovf_seen;
    logic [DENOM_W-1:0]   r_d, n_d;
    logic                 r_last, n_last;
    logic                 r_zero, n_zero;
    logic                 r_ovf, n_ovf;
    logic [SUM_W-1:0]     r_t, n_t;
    logic [SUM_W-1:0]     r_b, n_b;
    logic [SUM_W-1:0]     r_u, n_u;
    logic [SUM_W-1:0]     r_v, n_v;
    logic [SUM_W-1:0]     r_r, n_r;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;
    logic                 prod_hi;
    logic                 ovf_add;
    logic                 borrow;
    logic                 div_last;
    logic                 gcd_done;
    logic                 upd;

    ufsr_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // flags from the shared unit
    assign prod_hi  = |alu_rsp.prod[PROD_W-1:SUM_W];
    assign ovf_add  = r_ovf | alu_rsp.diff[SUM_W];
    assign borrow   = alu_rsp.diff[AW];
    assign div_last = (r_cnt == CNT_W'(SUM_W - 1));
    assign gcd_done = r_u[0] & r_v[0] & alu_rsp.zero;
    assign upd      = ~r_zero & ~r_ovf;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_denom == '0) ? S_FIN : S_MUL_N;
                end
            end
            S_MUL_N: n_state = S_MUL_D;
            S_MUL_D: n_state = S_ADD;
            S_ADD:   n_state = ovf_add ? S_FIN : S_GCD;
            S_GCD: begin
                if (gcd_done) begin
                    n_state = S_DIV_T;
                end
            end
            S_DIV_T: begin
                if (div_last) begin
                    n_state = S_DIV_B;
                end
            end
            S_DIV_B: begin
                if (div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // shared unit operands per state
    always_comb begin
        alu_req.op = ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        alu_req.m  = r_d;
        unique case (r_state)
            S_MUL_N: alu_req.a = {1'b0, r_num};
            S_MUL_D: alu_req.a = {1'b0, r_den};
            S_ADD: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {1'b0, r_t};
                alu_req.b  = {1'b0, r_den};
            end
            S_GCD: begin
                alu_req.a = {1'b0, r_u};
                alu_req.b = {1'b0, r_v};
            end
            S_DIV_T: begin
                alu_req.a = {r_r, r_t[SUM_W-1]};
                alu_req.b = {1'b0, r_u};
            end
            S_DIV_B: begin
                alu_req.a = {r_r, r_b[SUM_W-1]};
                alu_req.b = {1'b0, r_u};
            end
            default: alu_req.op = ALU_SUB;
        endcase
    end

    // result and handshake outputs
    always_comb begin
        o_ready                   = (r_state == S_IDLE);
        o_res_valid               = (r_state == S_FIN) && i_res_free;
        o_res.sum_numerator       = OUT_W'(upd ? r_t : r_num);
        o_res.sum_denominator     = OUT_W'(upd ? r_b : r_den);
        o_res.group_done          = r_last;
        o_res.overflow            = r_ovf_seen | r_ovf;
        o_res.zero_denominator    = r_zero;
    end

    // datapath next values
    always_comb begin
        n_num      = r_num;
        n_den      = r_den;
        n_ovf_seen = r_ovf_seen;
        n_d        = r_d;
        n_last     = r_last;
        n_zero     = r_zero;
        n_ovf      = r_ovf;
        n_t        = r_t;
        n_b        = r_b;
        n_u        = r_u;
        n_v        = r_v;
        n_r        = r_r;
        n_cnt      = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_d    = i_denom;
                    n_last = i_last;
                    n_zero = (i_denom == '0);
                    n_ovf  = 1'b0;
                end
            end
            // num * d
            S_MUL_N: begin
                n_t   = alu_rsp.prod[SUM_W-1:0];
                n_ovf = prod_hi;
            end
            // den * d
            S_MUL_D: begin
                n_b   = alu_rsp.prod[SUM_W-1:0];
                n_ovf = r_ovf | prod_hi;
            end
            // num * d + den, seed the gcd pair
            S_ADD: begin
                n_t   = alu_rsp.diff[SUM_W-1:0];
                n_ovf = ovf_add;
                n_u   = alu_rsp.diff[SUM_W-1:0];
                n_v   = r_b;
            end
            // binary gcd; common factors of two come off the operands directly
            S_GCD: begin
                if (!r_u[0] && !r_v[0]) begin
                    n_u = {1'b0, r_u[SUM_W-1:1]};
                    n_v = {1'b0, r_v[SUM_W-1:1]};
                    n_t = {1'b0, r_t[SUM_W-1:1]};
                    n_b = {1'b0, r_b[SUM_W-1:1]};
                end else if (!r_u[0]) begin
                    n_u = {1'b0, r_u[SUM_W-1:1]};
                end else if (!r_v[0]) begin
                    n_v = {1'b0, r_v[SUM_W-1:1]};
                end else if (alu_rsp.zero) begin
                    n_r   = '0;
                    n_cnt = '0;
                end else if (borrow) begin
                    n_u = r_v;
                    n_v = r_u;
                end else begin
                    n_u = {1'b0, alu_rsp.diff[SUM_W-1:1]};
                end
            end
            // restoring division of the numerator, one bit a cycle
            S_DIV_T: begin
                n_r   = borrow ? alu_req.a[SUM_W-1:0] : alu_rsp.diff[SUM_W-1:0];
                n_t   = {r_t[SUM_W-2:0], ~borrow};
                n_cnt = r_cnt + CNT_W'(1);
                if (div_last) begin
                    n_r   = '0;
                    n_cnt = '0;
                end
            end
            // restoring division of the denominator
            S_DIV_B: begin
                n_r   = borrow ? alu_req.a[SUM_W-1:0] : alu_rsp.diff[SUM_W-1:0];
                n_b   = {r_b[SUM_W-2:0], ~borrow};
                n_cnt = r_cnt + CNT_W'(1);
            end
            // commit the sum, clear after a group ends
            S_FIN: begin
                if (i_res_free) begin
                    if (upd) begin
                        n_num = r_t;
                        n_den = r_b;
                    end
                    if (r_ovf) begin
                        n_ovf_seen = 1'b1;
                    end
                    if (r_last) begin
                        n_num      = '0;
                        n_den      = SUM_W'(1);
                        n_ovf_seen = 1'b0;
                    end
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_num      <= '0;
            r_den      <= SUM_W'(1);
            r_ovf_seen <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_num      <= n_num;
            r_den      <= n_den;
            r_ovf_seen <= n_ovf_seen;
            r_cnt      <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_last <= n_last;
        r_zero <= n_zero;
        r_ovf  <= n_ovf;
        r_t    <= n_t;
        r_b    <= n_b;
        r_u    <= n_u;
        r_v    <= n_v;
        r_r    <= n_r;
    end

    `UFSR_ASSERT_IMPL(a_gcd_nonzero, i_clk, i_rst_n, r_state == S_GCD, (r_u != '0) && (r_v != '0))
    `UFSR_ASSERT_IMPL(a_rem_below, i_clk, i_rst_n, (r_state == S_DIV_T) || (r_state == S_DIV_B), r_r < r_u)
    `UFSR_ASSERT_IMPL(a_den_nonzero, i_clk, i_rst_n, o_res_valid, o_res.sum_denominator != '0)
    `UFSR_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && o_ready, r_state != S_IDLE)

endmodule

@@ rtl/unit_fraction_sum_reducer.sv @@
`timescale 1ns / 1ps
// channel   dir  fields
// i_in      in   denominator[15:0], last_term
// o_out     out  sum_numerator[31:0], sum_denominator[31:0], group_done, overflow,
//                zero_denominator
//
// a term runs through setup states S_MUL_N, S_MUL_D and S_ADD, a binary gcd loop on
// the shared add/subtract unit, restoring divisions of numerator and denominator
// and a result state; zero or overflowing terms skip the gcd and the divisions
// i_in.ready is high only while the sequencer is idle, one item at a time
// the result sits in an output register; a stalled o_out holds the next result back
// synchronous active-low reset clears the sum to 0/1 and the overflow flag
module unit_fraction_sum_reducer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ufsr_in_if.sink         i_in,
    ufsr_out_if.source      o_out
);
    import ufsr_pkg::*;

    logic       start;
    logic       res_free;
    logic       core_ready;
    logic       res_valid;
    t_result    res;
    t_result    r_out;
    logic       r_out_valid;

    assign start    = i_in.valid & core_ready;
    assign res_free = ~r_out_valid | o_out.ready;

    ufsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_denom     (i_in.denominator),
        .i_last      (i_in.last_term),
        .i_res_free  (res_free),
        .o_ready     (core_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign i_in.ready             = core_ready;
    assign o_out.valid            = r_out_valid;
    assign o_out.sum_numerator    = r_out.sum_numerator;
    assign o_out.sum_denominator  = r_out.sum_denominator;
    assign o_out.group_done       = r_out.group_done;
    assign o_out.overflow         = r_out.overflow;
    assign o_out.zero_denominator = r_out.zero_denominator;

endmodule
